FILE: design/imlu_pkg.sv
// ----------------------------------------------------------------------------
// imlu_pkg
// Shared types and constants for the Metropolis Ising lattice update block.
// ----------------------------------------------------------------------------
package imlu_pkg;

  // Default lattice size
  localparam int ROWS_DEF = 64;
  localparam int COLS_DEF = 64;

  // Field widths of the transaction ports
  localparam int OP_W     = 2;
  localparam int SITE_W   = 6;
  localparam int RND_W    = 32;
  localparam int THRESH_W = 33;
  localparam int CLASS_W  = 4;
  localparam int ENERGY_W = 15;
  localparam int SUM_W    = 40;
  localparam int CFG_IDX_W = 3;

  // Number of acceptance thresholds, one per local class
  localparam int NUM_THRESH = 5;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 33'h1_0000_0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_M4   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_M2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_P2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_P4   = 3'd4;

  // Saturation bounds of the sample sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET       = 2'd0,
    OP_ATTEMPT   = 2'd1,
    OP_SUM_ADD   = 2'd2,
    OP_SUM_CLEAR = 2'd3
  } op_e;

  typedef logic [THRESH_W-1:0] thresh_t;

  // Site evaluation outcome
  typedef struct packed {
    logic                      flip;
    logic                      spin_now;
    logic signed [CLASS_W-1:0] local_class;
  } eval_t;

endpackage

FILE: design/ising_metropolis_lattice_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_lattice_update
// 2D periodic Ising lattice kept in a row-word memory, with incremental
// total energy tracking, Metropolis attempts and a saturating sample sum.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o | operation, site, spin, random value
//  out      | out_valid_o/out_stall_i | flipped, spin_now, class, energy, sum
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_wdata_i
//
// Each transaction passes through accept, a read of the center and upper
// rows on two ports, a read of the lower row, then evaluate and write back.
// A new transaction is taken only once the last one has been evaluated.
// After reset a clearing pass writes all spins to +1; input stalls during
// it, configuration writes are taken.
// A stalled result holds in the output register and the evaluate step waits.
// ----------------------------------------------------------------------------
module ising_metropolis_lattice_update #(
  parameter int ROWS = imlu_pkg::ROWS_DEF,
  parameter int COLS = imlu_pkg::COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imlu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [imlu_pkg::THRESH_W-1:0]       cfg_wdata_i,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [imlu_pkg::OP_W-1:0]           operation_i,
  input  logic [imlu_pkg::SITE_W-1:0]         site_row_i,
  input  logic [imlu_pkg::SITE_W-1:0]         site_col_i,
  input  logic                                spin_value_i,
  input  logic [imlu_pkg::RND_W-1:0]          random_fraction_i,
  // result transactions
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                flipped_o,
  output logic                                spin_now_o,
  output logic signed [imlu_pkg::CLASS_W-1:0] local_class_o,
  output logic signed [imlu_pkg::ENERGY_W-1:0] energy_now_o,
  output logic signed [imlu_pkg::SUM_W-1:0]   energy_sum_o
);
  import imlu_pkg::*;

  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLS);
  localparam int SITES    = ROWS * COLS;
  localparam int EW_RAW   = $clog2(2 * SITES + 1) + 1;
  localparam int EW       = (EW_RAW > ENERGY_W) ? EW_RAW : ENERGY_W;
  localparam int NSITE    = 1 << SITE_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD0   = 5'b00100,
    S_RD1   = 5'b01000,
    S_EXEC  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [RW-1:0]        clr_q, clr_d;
  logic                 in_acc;
  logic                 out_free;
  logic                 fire;

  // Item registers
  op_e                  op_q;
  logic [RW-1:0]        r_q;
  logic [CW-1:0]        c_q;
  logic                 spin_q;
  logic [RND_W-1:0]     rnd_q;
  logic [RW-1:0]        r_up;
  logic [RW-1:0]        r_dn;

  // Site index wrap tables
  logic [RW-1:0]        row_wrap [NSITE];
  logic [CW-1:0]        col_wrap [NSITE];

  // Lattice memory
  logic [COLS-1:0]      lattice_mem [ROWS];
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [COLS-1:0]      mem_wdata;
  logic                 re_a, re_b;
  logic [RW-1:0]        addr_a, addr_b;
  logic [COLS-1:0]      rd_a_q, rd_b_q, up_q;

  // Architectural state
  thresh_t              thresh_q [NUM_THRESH];
  logic signed [EW-1:0] energy_q, energy_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W:0]   energy_ext;
  logic signed [SUM_W:0]   sum_tmp;
  logic signed [EW-1:0]    delta;

  eval_t                ev;

  // Output register
  logic                         out_valid_q;
  logic                         flipped_q;
  logic                         spin_now_q;
  logic signed [CLASS_W-1:0]    class_q;
  logic signed [ENERGY_W-1:0]   energy_out_q;
  logic signed [SUM_W-1:0]      sum_out_q;

  // Build wrap tables at elaboration
  for (genvar g = 0; g < NSITE; g++) begin : g_wrap
    assign row_wrap[g] = RW'(g % ROWS);
    assign col_wrap[g] = CW'(g % COLS);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign r_up = (r_q == '0) ? RW'(ROWS - 1) : r_q - RW'(1);
  assign r_dn = (r_q == RW'(ROWS - 1)) ? '0 : r_q + RW'(1);

  // Sequencer: clear pass, then read rows, evaluate and write back
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = r_q;
    mem_wdata = rd_a_q ^ (COLS'(1) << c_q);
    re_a      = 1'b0;
    re_b      = 1'b0;
    addr_a    = r_q;
    addr_b    = r_up;
    fire      = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '1;
        clr_d     = clr_q + RW'(1);
        if (clr_q == RW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        state_d = S_RD1;
      end
      S_RD1: begin
        re_b    = 1'b1;
        addr_b  = r_dn;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          fire    = 1'b1;
          mem_we  = ev.flip;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(operation_i);
      r_q    <= row_wrap[site_row_i];
      c_q    <= col_wrap[site_col_i];
      spin_q <= spin_value_i;
      rnd_q  <= random_fraction_i;
    end
  end

  // Row-word memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lattice_mem[mem_waddr] <= mem_wdata;
    end
    if (re_a) begin
      rd_a_q <= lattice_mem[addr_a];
    end
    if (re_b) begin
      rd_b_q <= lattice_mem[addr_b];
    end
  end

  // Park the upper row while port b fetches the lower one
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD1) begin
      up_q <= rd_b_q;
    end
  end

  imlu_site_eval #(
    .COLS (COLS)
  ) u_eval (
    .word_up_i    (up_q),
    .word_ctr_i   (rd_a_q),
    .word_dn_i    (rd_b_q),
    .col_i        (c_q),
    .op_i         (op_q),
    .spin_value_i (spin_q),
    .rnd_i        (rnd_q),
    .thresh_i     (thresh_q),
    .eval_o       (ev)
  );

  // Energy changes by twice the class on a flip
  assign delta    = EW'(ev.local_class) <<< 1;
  assign energy_d = ev.flip ? energy_q + delta : energy_q;

  // Saturating sample sum
  assign sum_ext    = {sum_q[SUM_W-1], sum_q};
  assign energy_ext = (SUM_W + 1)'(energy_q);
  assign sum_tmp    = sum_ext + energy_ext;

  always_comb begin
    case (op_q)
      OP_SUM_ADD: begin
        if (sum_tmp[SUM_W] != sum_tmp[SUM_W-1]) begin
          sum_d = sum_tmp[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_d = sum_tmp[SUM_W-1:0];
        end
      end
      OP_SUM_CLEAR: sum_d = '0;
      default:      sum_d = sum_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= EW'(-2 * SITES);
      sum_q    <= '0;
    end else if (fire) begin
      energy_q <= energy_d;
      sum_q    <= sum_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THRESH; i++) begin
        thresh_q[i] <= THRESH_RESET;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_THRESH_M4:   thresh_q[0] <= cfg_wdata_i;
        CFG_THRESH_M2:   thresh_q[1] <= cfg_wdata_i;
        CFG_THRESH_ZERO: thresh_q[2] <= cfg_wdata_i;
        CFG_THRESH_P2:   thresh_q[3] <= cfg_wdata_i;
        CFG_THRESH_P4:   thresh_q[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      flipped_q    <= ev.flip;
      spin_now_q   <= ev.spin_now;
      class_q      <= ev.local_class;
      energy_out_q <= energy_d[ENERGY_W-1:0];
      sum_out_q    <= sum_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign flipped_o     = flipped_q;
  assign spin_now_o    = spin_now_q;
  assign local_class_o = class_q;
  assign energy_now_o  = energy_out_q;
  assign energy_sum_o  = sum_out_q;

endmodule

FILE: design/imlu_site_eval.sv
// ----------------------------------------------------------------------------
// imlu_site_eval
// Evaluates one site from its three row words: local class, threshold
// choice and flip decision for set and Metropolis attempt operations.
// ----------------------------------------------------------------------------
module imlu_site_eval #(
  parameter int COLS = imlu_pkg::COLS_DEF
) (
  input  logic [COLS-1:0]          word_up_i,
  input  logic [COLS-1:0]          word_ctr_i,
  input  logic [COLS-1:0]          word_dn_i,
  input  logic [$clog2(COLS)-1:0]  col_i,
  input  imlu_pkg::op_e            op_i,
  input  logic                     spin_value_i,
  input  logic [imlu_pkg::RND_W-1:0] rnd_i,
  input  imlu_pkg::thresh_t        thresh_i [imlu_pkg::NUM_THRESH],
  output imlu_pkg::eval_t          eval_o
);
  import imlu_pkg::*;

  localparam int CW = $clog2(COLS);

  logic [CW-1:0]    col_l;
  logic [CW-1:0]    col_r;
  logic             s;
  logic [2:0]       cnt;
  logic signed [4:0] two_cnt;
  logic signed [4:0] nsum;
  logic signed [4:0] cls;
  logic [2:0]       idx;
  logic             flip;

  // Wrap the column neighbors
  assign col_l = (col_i == '0) ? CW'(COLS - 1) : col_i - CW'(1);
  assign col_r = (col_i == CW'(COLS - 1)) ? '0 : col_i + CW'(1);

  assign s   = word_ctr_i[col_i];
  assign cnt = {2'b00, word_up_i[col_i]} + {2'b00, word_dn_i[col_i]}
             + {2'b00, word_ctr_i[col_l]} + {2'b00, word_ctr_i[col_r]};

  // Neighbor sum is 2*ones - 4; class is spin times that sum
  assign two_cnt = {1'b0, cnt, 1'b0};
  assign nsum    = two_cnt - 5'sd4;
  assign cls     = s ? nsum : -nsum;

  // Threshold index (class + 4) / 2
  assign idx = s ? cnt : 3'd4 - cnt;

  always_comb begin
    case (op_i)
      OP_SET:     flip = (spin_value_i != s);
      OP_ATTEMPT: flip = ({1'b0, rnd_i} < thresh_i[idx]);
      default:    flip = 1'b0;
    endcase
  end

  assign eval_o.flip        = flip;
  assign eval_o.spin_now    = s ^ flip;
  assign eval_o.local_class = cls[CLASS_W-1:0];

endmodule

FILE: design/imlu_checker.sv
// ----------------------------------------------------------------------------
// imlu_checker
// Port-level checks for the Ising lattice update block, bound to the top.
// ----------------------------------------------------------------------------
module imlu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [imlu_pkg::CLASS_W-1:0] local_class_o,
  input logic signed [imlu_pkg::ENERGY_W-1:0] energy_now_o,
  input logic signed [imlu_pkg::SUM_W-1:0]   energy_sum_o
);

  // Busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while block stayed ready");

  // A result appears only after work on a transaction
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in flight");

  // Local class is one of the five legal values
  a_class_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (local_class_o == -4'sd4 || local_class_o == -4'sd2 ||
                     local_class_o == 4'sd0 || local_class_o == 4'sd2 ||
                     local_class_o == 4'sd4))
    else $error("illegal local class on result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(energy_now_o) && $stable(energy_sum_o)))
    else $error("stalled result changed");

endmodule

bind ising_metropolis_lattice_update imlu_checker u_imlu_checker (.*);
